FILE: hdl/iou_greedy_tracker_stationary_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IoU greedy tracker
// Shared assertion forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef IOU_GREEDY_TRACKER_STATIONARY_DEFINES_SVH
`define IOU_GREEDY_TRACKER_STATIONARY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IGT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/igt_pkg.sv
// ----------------------------------------------------------------------------
// igt_pkg
// Types and fixed constants shared by the IoU greedy tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package igt_pkg;

  // Command codes.
  localparam logic [1:0] OP_DETECT = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // Motion status codes.
  localparam logic [1:0] MS_UNKNOWN   = 2'd0;
  localparam logic [1:0] MS_MOVING    = 2'd1;
  localparam logic [1:0] MS_STOPPING  = 2'd2;
  localparam logic [1:0] MS_SPLITTING = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH_IOU_MIN  = 2'd0;
  localparam logic [1:0] REG_STILL_IOU_BASE = 2'd1;
  localparam logic [1:0] REG_SCORE_MIN      = 2'd2;
  localparam logic [1:0] REG_LENGTH_MIN     = 2'd3;

  // Stationary classifier constants (margin is 0.05 in Q0.16).
  localparam int unsigned STILL_MARGIN = 3277;
  localparam int unsigned AREA_LIMIT   = 2500;
  localparam int unsigned STILL_LIMIT  = 22;

  // Result buffer depth for one transaction.
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RIW = $clog2(MAX_RESULTS);
  localparam int unsigned RCW = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] det_score;
  } in_t;

  typedef struct packed {
    logic [31:0] rep_id;
    logic [31:0] start_frame;
    logic [15:0] length;
    logic [15:0] peak_score;
    logic [1:0]  motion_status;
    logic [15:0] last_x;
    logic [15:0] last_y;
    logic [15:0] last_w;
    logic [15:0] last_h;
    logic        overflow_seen;
    logic        last_report;
  } out_t;

endpackage

FILE: hdl/igt_iou.sv
// ----------------------------------------------------------------------------
// igt_iou
// Three-stage pipeline giving the exact IoU of two boxes as numerator and
// denominator (intersection and union); apart boxes and a zero union give 0/1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module igt_iou (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  igt_pkg::box_t a_i,
  input  igt_pkg::box_t b_i,
  output logic          valid_o,
  output logic [31:0]   num_o,
  output logic [32:0]   den_o
);
  import igt_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic        apart1_q, apart2_q;
  logic [15:0] dx_q, dy_q;
  logic [15:0] aw_q, ah_q, bw_q, bh_q;
  logic [31:0] inter_q, aa_q, ab_q;
  logic [31:0] num_q;
  logic [32:0] den_q;

  logic [16:0] ax2, ay2, bx2, by2;
  logic [15:0] xl, yt;
  logic [16:0] xr, yb, dx, dy;
  logic        apart;
  logic [32:0] uni;

  // Edge extents and the overlap along each axis.
  always_comb begin
    ax2   = {1'b0, a_i.x} + {1'b0, a_i.w};
    ay2   = {1'b0, a_i.y} + {1'b0, a_i.h};
    bx2   = {1'b0, b_i.x} + {1'b0, b_i.w};
    by2   = {1'b0, b_i.y} + {1'b0, b_i.h};
    apart = ({1'b0, a_i.x} > bx2) || (ax2 < {1'b0, b_i.x}) ||
            ({1'b0, a_i.y} > by2) || (ay2 < {1'b0, b_i.y});
    xl    = (a_i.x > b_i.x) ? a_i.x : b_i.x;
    yt    = (a_i.y > b_i.y) ? a_i.y : b_i.y;
    xr    = (ax2 < bx2) ? ax2 : bx2;
    yb    = (ay2 < by2) ? ay2 : by2;
    dx    = xr - {1'b0, xl};
    dy    = yb - {1'b0, yt};
    uni   = {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, inter_q};
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Overlap, then products, then union and the zero-union rule.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      apart1_q <= apart;
      dx_q     <= dx[15:0];
      dy_q     <= dy[15:0];
      aw_q     <= a_i.w;
      ah_q     <= a_i.h;
      bw_q     <= b_i.w;
      bh_q     <= b_i.h;
    end
    if (v1_q) begin
      apart2_q <= apart1_q;
      inter_q  <= dx_q * dy_q;
      aa_q     <= aw_q * ah_q;
      ab_q     <= bw_q * bh_q;
    end
    if (v2_q) begin
      if (apart2_q || (uni == 33'd0)) begin
        num_q <= 32'd0;
        den_q <= 33'd1;
      end else begin
        num_q <= inter_q;
        den_q <= uni;
      end
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

FILE: hdl/iou_greedy_tracker_stationary.sv
// ----------------------------------------------------------------------------
// iou_greedy_tracker_stationary
// Greedy IoU multi-object tracker with a stationary-motion classifier.
// ----------------------------------------------------------------------------
// Usage: a command is taken when start is high and busy is low. A detection
// command is stored without leaving idle. A close-frame command matches every
// live track, oldest first, against the buffered detections; a flush command
// reports every live track that qualifies and restarts frame and id numbering.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while busy
// is low; the user must keep to this, as the block itself does not enforce it.
// Reports of a command are collected in a result buffer and then played out
// one per cycle, each marked by strobe_o for a single cycle; the receiver
// cannot stall them. The last report of a command carries last_report, and
// overflow_seen shows the sticky overflow flag as it stands at command end.
// Per live track, a close runs each unused detection through the IoU pipeline
// and the serial best-match compare, skips detections already taken, and then
// updates or drops the track; leftover detections then open new tracks. A
// flush walks the live tracks in age order. A detection keeps busy low
// throughout.
// Reset clears all tracks and buffered detections; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iou_greedy_tracker_stationary #(
  parameter int unsigned MAX_TRACKS = 32,
  parameter int unsigned MAX_DETS   = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  igt_pkg::in_t  req_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [16:0]   cfg_data_i,
  output logic          strobe_o,
  output igt_pkg::out_t res_o
);
  import igt_pkg::*;

  localparam int unsigned IW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_TRACKS + 1);
  localparam int unsigned DIW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int unsigned DCW = $clog2(MAX_DETS + 1);
  localparam logic [15:0] CMASK = 16'((32'd1 << COORD_BITS) - 32'd1);

  typedef struct packed {
    box_t        box;
    logic [15:0] score;
  } det_t;

  typedef struct packed {
    box_t        box;
    logic [15:0] len;
    logic [15:0] peak;
    logic [1:0]  status;
    logic [7:0]  still;
    logic [31:0] begin_frame;
  } trk_t;

  typedef struct packed {
    logic [31:0] rep_id;
    logic [31:0] start_frame;
    logic [15:0] len;
    logic [15:0] peak;
    logic [1:0]  status;
    box_t        box;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_AGE_RD, S_TRK_RD, S_TRK_WAIT, S_DET, S_IOU_GO, S_IOU_WAIT,
    S_CMP, S_THR1, S_THR2, S_UPD_RD, S_UPD_WR, S_DROP, S_NEW_CHK, S_NEW_WR,
    S_CLOSE_END, S_FL_RD, S_FL_TRK, S_FL_EMIT, S_FL_END, S_OUT
  } state_e;

  // Configuration registers.
  logic [16:0] match_min_q, still_base_q;
  logic [15:0] score_min_q, len_min_q;

  // Control state.
  state_e                state_q;
  logic [DCW-1:0]        fill_q, d_q;
  logic [MAX_DETS-1:0]   used_q;
  logic [CW-1:0]         live_q, rd_q, wr_q;
  logic [MAX_TRACKS-1:0] mask_q;
  logic [31:0]           frame_no_q, next_id_q;
  logic                  ovf_q;
  logic [RCW-1:0]        res_cnt_q, out_rd_q;
  logic                  strobe_q, last_q, best_v_q;

  // Working registers of the current track.
  logic [IW-1:0]         slot_q;
  logic [DIW-1:0]        best_q;
  logic [31:0]           bn_q;
  logic [32:0]           bd_q;
  logic [64:0]           p1_q, p2_q;
  logic [49:0]           pm_q;
  logic [31:0]           area_q;
  logic signed [52:0]    pt_q;

  // Memories and their read registers.
  det_t          det_mem [MAX_DETS];
  trk_t          trk_mem [MAX_TRACKS];
  logic [IW-1:0] age_mem [MAX_TRACKS];
  rec_t          res_mem [MAX_RESULTS];
  det_t          det_rd_q;
  trk_t          trk_rd_q;
  logic [IW-1:0] age_rd_q;
  rec_t          res_rd_q;

  // Memory port controls.
  logic           det_we, det_re, trk_we, trk_re, age_we, age_re, res_we, res_re;
  logic [DIW-1:0] det_wa, det_ra;
  logic [IW-1:0]  trk_wa, trk_ra, age_wa, age_ra, age_wd;
  logic [RIW-1:0] res_ra;
  det_t           det_wd;
  trk_t           trk_wd;
  rec_t           res_wd;

  // IoU unit.
  logic        iou_start, iou_valid;
  logic [31:0] iou_num;
  logic [32:0] iou_den;

  // Miscellaneous decode.
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic                  qual, room, emit_st;
  logic [31:0]           nid_inc, nid_nx;
  logic signed [18:0]    thr;
  logic                  stop;
  logic [7:0]            still_nx;
  logic [1:0]            status_nx;
  logic [15:0]           peak_nx;

  igt_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start),
    .a_i     (trk_rd_q.box),
    .b_i     (det_rd_q.box),
    .valid_o (iou_valid),
    .num_o   (iou_num),
    .den_o   (iou_den)
  );

  // Lowest free track slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (!mask_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Report qualification, id advance and the motion update of a match.
  always_comb begin
    qual    = (trk_rd_q.peak >= score_min_q) && (trk_rd_q.len >= len_min_q);
    room    = (res_cnt_q < RCW'(MAX_RESULTS));
    emit_st = (state_q == S_DROP) || (state_q == S_FL_EMIT);
    nid_inc = next_id_q + 32'd1;
    nid_nx  = (nid_inc == 32'd0) ? 32'd1 : nid_inc;
    if (area_q > 32'(AREA_LIMIT)) begin
      thr = $signed({2'b00, still_base_q}) + 19'sd3277;
    end else begin
      thr = $signed({2'b00, still_base_q}) - 19'sd3277;
    end
    stop = $signed({5'b00000, bn_q, 16'h0000}) > pt_q;
    if (stop) begin
      still_nx  = (trk_rd_q.still == 8'hFF) ? 8'hFF : trk_rd_q.still + 8'd1;
      status_nx = MS_STOPPING;
    end else begin
      still_nx  = 8'd0;
      status_nx = MS_MOVING;
    end
    if (still_nx > 8'(STILL_LIMIT)) begin
      status_nx = MS_SPLITTING;
    end
    peak_nx = (det_rd_q.score > trk_rd_q.peak) ? det_rd_q.score : trk_rd_q.peak;
  end

  // Memory port decode per state.
  always_comb begin
    det_we = 1'b0;
    det_wa = fill_q[DIW-1:0];
    det_wd.box.x = req_i.box_x & CMASK;
    det_wd.box.y = req_i.box_y & CMASK;
    det_wd.box.w = req_i.box_w & CMASK;
    det_wd.box.h = req_i.box_h & CMASK;
    det_wd.score = req_i.det_score;
    det_re = 1'b0;
    det_ra = d_q[DIW-1:0];
    trk_re = 1'b0;
    trk_ra = age_rd_q;
    trk_we = 1'b0;
    trk_wa = slot_q;
    trk_wd.box         = det_rd_q.box;
    trk_wd.len         = (trk_rd_q.len == 16'hFFFF) ? trk_rd_q.len : trk_rd_q.len + 16'd1;
    trk_wd.peak        = peak_nx;
    trk_wd.status      = status_nx;
    trk_wd.still       = still_nx;
    trk_wd.begin_frame = trk_rd_q.begin_frame;
    age_re = 1'b0;
    age_ra = rd_q[IW-1:0];
    age_we = 1'b0;
    age_wa = wr_q[IW-1:0];
    age_wd = slot_q;
    res_we = emit_st && qual && room;
    res_wd.rep_id      = next_id_q;
    res_wd.start_frame = trk_rd_q.begin_frame;
    res_wd.len         = trk_rd_q.len;
    res_wd.peak        = trk_rd_q.peak;
    res_wd.status      = trk_rd_q.status;
    res_wd.box         = trk_rd_q.box;
    res_re = (state_q == S_OUT) && (out_rd_q < res_cnt_q);
    res_ra = out_rd_q[RIW-1:0];
    iou_start = (state_q == S_IOU_GO);
    unique case (state_q)
      S_IDLE: begin
        det_we = start && (req_i.opcode == OP_DETECT) && (fill_q < DCW'(MAX_DETS));
      end
      S_AGE_RD, S_FL_RD: begin
        age_re = (rd_q < live_q);
      end
      S_TRK_RD, S_FL_TRK: begin
        trk_re = 1'b1;
      end
      S_DET: begin
        det_re = (d_q != fill_q) && !used_q[d_q[DIW-1:0]];
      end
      S_UPD_RD: begin
        det_re = 1'b1;
        det_ra = best_q;
      end
      S_UPD_WR: begin
        trk_we = 1'b1;
        age_we = 1'b1;
      end
      S_NEW_CHK: begin
        det_re = (d_q != fill_q) && !used_q[d_q[DIW-1:0]] && free_found;
      end
      S_NEW_WR: begin
        trk_we = 1'b1;
        trk_wa = free_idx;
        trk_wd.box         = det_rd_q.box;
        trk_wd.len         = 16'd1;
        trk_wd.peak        = det_rd_q.score;
        trk_wd.status      = MS_UNKNOWN;
        trk_wd.still       = 8'd0;
        trk_wd.begin_frame = frame_no_q;
        age_we = 1'b1;
        age_wa = live_q[IW-1:0];
        age_wd = free_idx;
      end
      default: begin
      end
    endcase
  end

  // Memories: one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (det_we) det_mem[det_wa] <= det_wd;
    if (det_re) det_rd_q <= det_mem[det_ra];
  end

  always_ff @(posedge clk_i) begin
    if (trk_we) trk_mem[trk_wa] <= trk_wd;
    if (trk_re) trk_rd_q <= trk_mem[trk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (age_we) age_mem[age_wa] <= age_wd;
    if (age_re) age_rd_q <= age_mem[age_ra];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[res_cnt_q[RIW-1:0]] <= res_wd;
    if (res_re) res_rd_q <= res_mem[res_ra];
  end

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_min_q  <= 17'd19661;
      still_base_q <= 17'd58982;
      score_min_q  <= 16'd32768;
      len_min_q    <= 16'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MATCH_IOU_MIN:  match_min_q  <= cfg_data_i;
        REG_STILL_IOU_BASE: still_base_q <= cfg_data_i;
        REG_SCORE_MIN:      score_min_q  <= cfg_data_i[15:0];
        REG_LENGTH_MIN:     len_min_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      d_q        <= '0;
      used_q     <= '0;
      live_q     <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      mask_q     <= '0;
      frame_no_q <= 32'd0;
      next_id_q  <= 32'd1;
      ovf_q      <= 1'b0;
      res_cnt_q  <= '0;
      out_rd_q   <= '0;
      strobe_q   <= 1'b0;
      last_q     <= 1'b0;
      best_v_q   <= 1'b0;
      slot_q     <= '0;
      best_q     <= '0;
      bn_q       <= 32'd0;
      bd_q       <= 33'd1;
      p1_q       <= '0;
      p2_q       <= '0;
      pm_q       <= '0;
      area_q     <= '0;
      pt_q       <= '0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      // A report is either buffered or counted as an overflow.
      if (emit_st && qual) begin
        if (room) begin
          res_cnt_q <= res_cnt_q + RCW'(1);
          next_id_q <= nid_nx;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            rd_q      <= '0;
            wr_q      <= '0;
            res_cnt_q <= '0;
            out_rd_q  <= '0;
            case (req_i.opcode)
              OP_DETECT: begin
                if (fill_q < DCW'(MAX_DETS)) begin
                  used_q[fill_q[DIW-1:0]] <= 1'b0;
                  fill_q <= fill_q + DCW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_CLOSE: state_q <= S_AGE_RD;
              OP_FLUSH: state_q <= S_FL_RD;
              default: begin
              end
            endcase
          end
        end
        // Association pass over the live tracks, oldest first.
        S_AGE_RD: begin
          if (rd_q < live_q) begin
            state_q <= S_TRK_RD;
          end else begin
            live_q  <= wr_q;
            d_q     <= '0;
            state_q <= S_NEW_CHK;
          end
        end
        S_TRK_RD: begin
          slot_q  <= age_rd_q;
          state_q <= S_TRK_WAIT;
        end
        S_TRK_WAIT: begin
          best_v_q <= 1'b0;
          bn_q     <= 32'd0;
          bd_q     <= 33'd1;
          d_q      <= '0;
          state_q  <= S_DET;
        end
        S_DET: begin
          if (d_q == fill_q) begin
            state_q <= S_THR1;
          end else if (used_q[d_q[DIW-1:0]]) begin
            d_q <= d_q + DCW'(1);
          end else begin
            state_q <= S_IOU_GO;
          end
        end
        S_IOU_GO: begin
          state_q <= S_IOU_WAIT;
        end
        S_IOU_WAIT: begin
          if (iou_valid) begin
            p1_q    <= iou_num * bd_q;
            p2_q    <= bn_q * iou_den;
            state_q <= S_CMP;
          end
        end
        // Later detections win ties.
        S_CMP: begin
          if (p1_q >= p2_q) begin
            best_v_q <= 1'b1;
            best_q   <= d_q[DIW-1:0];
            bn_q     <= iou_num;
            bd_q     <= iou_den;
          end
          d_q     <= d_q + DCW'(1);
          state_q <= S_DET;
        end
        S_THR1: begin
          if (!best_v_q) begin
            state_q <= S_DROP;
          end else begin
            pm_q    <= match_min_q * bd_q;
            area_q  <= trk_rd_q.box.w * trk_rd_q.box.h;
            state_q <= S_THR2;
          end
        end
        S_THR2: begin
          if ({2'b00, bn_q, 16'h0000} >= pm_q) begin
            pt_q    <= thr * $signed({1'b0, bd_q});
            state_q <= S_UPD_RD;
          end else begin
            state_q <= S_DROP;
          end
        end
        S_UPD_RD: begin
          state_q <= S_UPD_WR;
        end
        S_UPD_WR: begin
          used_q[best_q] <= 1'b1;
          wr_q    <= wr_q + CW'(1);
          rd_q    <= rd_q + CW'(1);
          state_q <= S_AGE_RD;
        end
        S_DROP: begin
          mask_q[slot_q] <= 1'b0;
          rd_q    <= rd_q + CW'(1);
          state_q <= S_AGE_RD;
        end
        // Leftover detections open new tracks.
        S_NEW_CHK: begin
          if (d_q == fill_q) begin
            state_q <= S_CLOSE_END;
          end else if (used_q[d_q[DIW-1:0]]) begin
            d_q <= d_q + DCW'(1);
          end else if (!free_found) begin
            ovf_q <= 1'b1;
            d_q   <= d_q + DCW'(1);
          end else begin
            state_q <= S_NEW_WR;
          end
        end
        S_NEW_WR: begin
          mask_q[free_idx] <= 1'b1;
          live_q  <= live_q + CW'(1);
          d_q     <= d_q + DCW'(1);
          state_q <= S_NEW_CHK;
        end
        S_CLOSE_END: begin
          used_q     <= '0;
          fill_q     <= '0;
          frame_no_q <= frame_no_q + 32'd1;
          state_q    <= S_OUT;
        end
        // Flush reports every live track that qualifies, in age order.
        S_FL_RD: begin
          state_q <= (rd_q < live_q) ? S_FL_TRK : S_FL_END;
        end
        S_FL_TRK: begin
          slot_q  <= age_rd_q;
          state_q <= S_FL_EMIT;
        end
        S_FL_EMIT: begin
          rd_q    <= rd_q + CW'(1);
          state_q <= S_FL_RD;
        end
        S_FL_END: begin
          live_q     <= '0;
          mask_q     <= '0;
          used_q     <= '0;
          fill_q     <= '0;
          frame_no_q <= 32'd0;
          next_id_q  <= 32'd1;
          state_q    <= S_OUT;
        end
        // Play out the buffered reports, one per cycle.
        S_OUT: begin
          if (out_rd_q < res_cnt_q) begin
            out_rd_q <= out_rd_q + RCW'(1);
            strobe_q <= 1'b1;
            last_q   <= (out_rd_q == res_cnt_q - RCW'(1));
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output ports.
  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;

  always_comb begin
    res_o.rep_id        = res_rd_q.rep_id;
    res_o.start_frame   = res_rd_q.start_frame;
    res_o.length        = res_rd_q.len;
    res_o.peak_score    = res_rd_q.peak;
    res_o.motion_status = res_rd_q.status;
    res_o.last_x        = res_rd_q.box.x;
    res_o.last_y        = res_rd_q.box.y;
    res_o.last_w        = res_rd_q.box.w;
    res_o.last_h        = res_rd_q.box.h;
    res_o.overflow_seen = ovf_q;
    res_o.last_report   = last_q;
  end

  `include "iou_greedy_tracker_stationary_defines.svh"

  // Checks.
  `IGT_ASSERT_NEXT(a_last_ends, strobe_o && res_o.last_report, !strobe_o, "report after last")
  `IGT_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag cleared")
  `IGT_ASSERT_IMPL(a_mask_live, state_q == S_IDLE, $countones(mask_q) == live_q, "slot mask")

endmodule
